// ===== sv/gab_pkg.sv =====
// gab_pkg: shared constants and types for the glyph alpha-over blender.
// No dependencies; imported by glyph_alpha_over_blend.
`timescale 1ns / 1ps
package gab_pkg;
   localparam int unsigned QFRAC   = 15;
   localparam logic [15:0] Q_ONE     = 16'd32768;
   localparam logic [15:0] Q_HALF    = 16'd16384;
   localparam logic [15:0] HI_THRESH = 16'd32440;
   localparam logic [15:0] LO_THRESH = 16'd328;

   // reciprocals for the rounded alpha divides by 65025 and 255
   localparam logic [31:0] SA_RECIP = 32'd2164359683;
   localparam int unsigned SA_SHIFT = 47;
   localparam logic [23:0] DA_RECIP = 24'd8421505;
   localparam int unsigned DA_SHIFT = 31;

   // csr register indexes
   typedef enum logic [2:0] {
      REG_RED   = 3'd0,
      REG_GREEN = 3'd1,
      REG_BLUE  = 3'd2,
      REG_ALPHA = 3'd3,
      REG_CHANS = 3'd4
   } reg_index_type;

   // pixel as four bytes, red first
   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
   } pixel_type;
endpackage

// ===== sv/gab_div_cell.sv =====
// gab_div_cell: one restoring-division step, resolves one quotient bit.
// Uses no package items; instantiated by gab_div.
`timescale 1ns / 1ps
module gab_div_cell #(
   parameter int unsigned NW    = 24,
   parameter int unsigned DW    = 16,
   parameter int unsigned QW    = 8,
   parameter int unsigned SW    = 1,
   parameter int unsigned SHIFT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [NW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [QW-1:0] in_quo,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_rem,
   output logic [DW-1:0] out_den,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   logic [NW+DW-1:0] trial_w;
   logic             ge_w;
   logic             valid_ff;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [SW-1:0]    side_ff;

   always_comb begin
      trial_w = (NW+DW)'(in_den) << SHIFT;
      ge_w    = {{DW{1'b0}}, in_rem} >= trial_w;
      rem_in  = ge_w ? in_rem - trial_w[NW-1:0] : in_rem;
      quo_in  = in_quo;
      quo_in[SHIFT] = ge_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;
endmodule

// ===== sv/gab_div.sv =====
// gab_div: chain of QW division cells, one quotient bit per cell, MSB first.
// Depends on gab_div_cell. Numerator must stay below den * 2**QW.
`timescale 1ns / 1ps
module gab_div #(
   parameter int unsigned NW = 24,
   parameter int unsigned DW = 16,
   parameter int unsigned QW = 8,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   logic          v_w    [QW+1];
   logic [NW-1:0] rem_w  [QW+1];
   logic [DW-1:0] den_w  [QW+1];
   logic [QW-1:0] quo_w  [QW+1];
   logic [SW-1:0] side_w [QW+1];

   assign v_w[0]    = in_valid;
   assign rem_w[0]  = in_num;
   assign den_w[0]  = in_den;
   assign quo_w[0]  = '0;
   assign side_w[0] = in_side;

   for (genvar k = 0; k < QW; k++) begin : g_cell
      gab_div_cell #(
         .NW(NW), .DW(DW), .QW(QW), .SW(SW), .SHIFT(QW-1-k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_valid (v_w[k]),
         .in_rem   (rem_w[k]),
         .in_den   (den_w[k]),
         .in_quo   (quo_w[k]),
         .in_side  (side_w[k]),
         .out_valid(v_w[k+1]),
         .out_rem  (rem_w[k+1]),
         .out_den  (den_w[k+1]),
         .out_quo  (quo_w[k+1]),
         .out_side (side_w[k+1])
      );
   end

   assign out_valid = v_w[QW];
   assign out_quo   = quo_w[QW];
   assign out_side  = side_w[QW];
endmodule

// ===== sv/glyph_alpha_over_blend.sv =====
// glyph_alpha_over_blend: straight-alpha "over" of the text color on a pixel.
// Depends on gab_pkg and gab_div (chains of gab_div_cell).
`timescale 1ns / 1ps
// Usage:
//  - req_* carries one destination pixel plus its glyph coverage byte per item;
//    rsp_* returns the blended pixel. One result per item, in order.
//  - csr_* writes the text color, text alpha and channel count; write only
//    while the block is empty. csr_ready is always high.
//  - Throughput: one item per clock while the receiver takes results. Path:
//    capture, alpha reciprocal multiply, combined alpha, channel products
//    and numerators (five stages), then a chain of 8 restoring-division cells
//    for the per-channel un-premultiply, then the output register.
//  - The whole pipeline advances together whenever the output register is
//    empty or being taken. When the receiver stalls with a result held, the
//    pipeline freezes and req_tready drops; nothing is lost or repeated.
//  - Reset (synchronous, active high) empties the pipeline and restores the
//    register defaults: black text, alpha 255, four channels.
module glyph_alpha_over_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // coverage[7:0], dst_red[15:8], dst_green[23:16], dst_blue[31:24],
   // dst_alpha[39:32]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import gab_pkg::*;

   // ---------------- configuration registers
   logic [7:0] red_ff, green_ff, blue_ff, talpha_ff;
   logic [2:0] chans_ff;
   logic       four_w;

   assign csr_ready = 1'b1;
   assign four_w    = chans_ff >= 3'd4;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff    <= 8'd0;
         green_ff  <= 8'd0;
         blue_ff   <= 8'd0;
         talpha_ff <= 8'd255;
         chans_ff  <= 3'd4;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RED:   red_ff    <= csr_data;
            REG_GREEN: green_ff  <= csr_data;
            REG_BLUE:  blue_ff   <= csr_data;
            REG_ALPHA: talpha_ff <= csr_data;
            REG_CHANS: chans_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   logic [7:0] col_w [3];
   assign col_w[0] = red_ff;
   assign col_w[1] = green_ff;
   assign col_w[2] = blue_ff;

   // ---------------- global advance
   logic adv_w;
   assign adv_w      = rsp_tready || !rsp_tvalid;
   assign req_tready = adv_w;

   // ---------------- stage 1: capture, coverage times text alpha
   logic        s1_v_ff;
   logic [7:0]  s1_cov_ff;
   logic [15:0] s1_p_ff;
   pixel_type   s1_dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv_w) begin
         s1_v_ff <= req_tvalid;
      end
      if (adv_w) begin
         s1_cov_ff <= req_tdata[7:0];
         s1_p_ff   <= 16'(req_tdata[7:0]) * 16'(talpha_ff);
         s1_dst_ff <= req_tdata[39:8];
      end
   end

   // ---------------- stage 2: source and destination alphas
   // rounded divides by 65025 and 255 as reciprocal multiplies, exact over
   // the full numerator range
   logic [30:0] sa_num_w;
   logic [22:0] da_num_w;
   logic [62:0] sa_prod_w;
   logic [46:0] da_prod_w;
   assign sa_num_w  = (31'(s1_p_ff) << QFRAC) + 31'd32512;
   assign da_num_w  = (23'(s1_dst_ff.a) << QFRAC) + 23'd127;
   assign sa_prod_w = 63'(sa_num_w) * 63'(SA_RECIP);
   assign da_prod_w = 47'(da_num_w) * 47'(DA_RECIP);

   logic        s2_v_ff;
   logic [15:0] s2_sa_ff, s2_da_ff;
   logic [7:0]  s2_cov_ff;
   pixel_type   s2_dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv_w) begin
         s2_v_ff <= s1_v_ff;
      end
      if (adv_w) begin
         s2_sa_ff  <= sa_prod_w[SA_SHIFT+15:SA_SHIFT];
         s2_da_ff  <= da_prod_w[DA_SHIFT+15:DA_SHIFT];
         s2_cov_ff <= s1_cov_ff;
         s2_dst_ff <= s1_dst_ff;
      end
   end

   // ---------------- stage 3: select dst alpha, da * (1 - sa)
   logic [15:0] das_w, w_w;
   assign das_w = four_w ? s2_da_ff : Q_ONE;
   assign w_w   = Q_ONE - s2_sa_ff;

   logic        s3_v_ff, s3_hi_ff;
   logic [15:0] s3_sa_ff, s3_da_ff, s3_w_ff;
   logic [31:0] s3_m_ff;
   logic [7:0]  s3_cov_ff;
   pixel_type   s3_dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv_w) begin
         s3_v_ff <= s2_v_ff;
      end
      if (adv_w) begin
         s3_hi_ff  <= (s2_sa_ff > HI_THRESH) && (das_w > HI_THRESH);
         s3_sa_ff  <= s2_sa_ff;
         s3_da_ff  <= das_w;
         s3_w_ff   <= w_w;
         s3_m_ff   <= 32'(das_w) * 32'(w_w);
         s3_cov_ff <= s2_cov_ff;
         s3_dst_ff <= s2_dst_ff;
      end
   end

   // ---------------- stage 4: combined alpha and channel products
   logic [32:0] t_w;
   assign t_w = (33'(s3_sa_ff) << QFRAC) + 33'(s3_m_ff) + 33'(Q_HALF);

   logic        s4_v_ff, s4_hi_ff;
   logic [15:0] s4_oa_ff, s4_w_ff;
   logic [23:0] s4_pc_ff [3];
   logic [23:0] s4_pd_ff [3];
   logic [7:0]  s4_cov_ff;
   pixel_type   s4_dst_ff;
   logic [7:0]  s3_dc_w [3];
   assign s3_dc_w[0] = s3_dst_ff.r;
   assign s3_dc_w[1] = s3_dst_ff.g;
   assign s3_dc_w[2] = s3_dst_ff.b;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv_w) begin
         s4_v_ff <= s3_v_ff;
      end
      if (adv_w) begin
         s4_hi_ff  <= s3_hi_ff;
         s4_oa_ff  <= t_w[QFRAC+15:QFRAC];
         s4_w_ff   <= s3_w_ff;
         s4_cov_ff <= s3_cov_ff;
         s4_dst_ff <= s3_dst_ff;
         for (int i = 0; i < 3; i++) begin
            s4_pc_ff[i] <= 24'(col_w[i]) * 24'(s3_sa_ff);
            s4_pd_ff[i] <= 24'(s3_dc_w[i]) * 24'(s3_da_ff);
         end
      end
   end

   // ---------------- stage 5: numerators scaled by 2**-15, saturation check
   logic [38:0] q_w [3];
   logic [23:0] n_w [3];
   for (genvar i = 0; i < 3; i++) begin : g_num
      assign q_w[i] = 39'(s4_pd_ff[i]) * 39'(s4_w_ff);
      assign n_w[i] = s4_pc_ff[i] + q_w[i][QFRAC+23:QFRAC];
   end

   logic        s5_v_ff, s5_hi_ff;
   logic [15:0] s5_oa_ff;
   logic [23:0] s5_n_ff [3];
   logic [2:0]  s5_sat_ff;
   logic [7:0]  s5_cov_ff;
   pixel_type   s5_dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv_w) begin
         s5_v_ff <= s4_v_ff;
      end
      if (adv_w) begin
         s5_hi_ff  <= s4_hi_ff;
         s5_oa_ff  <= s4_oa_ff;
         s5_cov_ff <= s4_cov_ff;
         s5_dst_ff <= s4_dst_ff;
         for (int i = 0; i < 3; i++) begin
            s5_n_ff[i]   <= n_w[i];
            s5_sat_ff[i] <= n_w[i] >= (24'(s4_oa_ff) << 8);
         end
      end
   end

   // ---------------- channel dividers (8 cells each)
   // a saturated channel violates the divider's range but is overridden
   localparam int unsigned SIDE0 = 16 + 1 + 1 + 8 + 32;
   logic             c_v_w [3];
   logic [7:0]       c_q_w [3];
   logic [SIDE0-1:0] side0_in_w, side0_out_w;
   logic             sat1_w, sat2_w;

   assign side0_in_w = {s5_oa_ff, s5_hi_ff, s5_sat_ff[0], s5_cov_ff, s5_dst_ff};

   gab_div #(.NW(24), .DW(16), .QW(8), .SW(SIDE0)) u_div_r (
      .clock(clock), .reset(reset), .enable(adv_w),
      .in_valid(s5_v_ff), .in_num(s5_n_ff[0]), .in_den(s5_oa_ff),
      .in_side(side0_in_w),
      .out_valid(c_v_w[0]), .out_quo(c_q_w[0]), .out_side(side0_out_w)
   );
   gab_div #(.NW(24), .DW(16), .QW(8), .SW(1)) u_div_g (
      .clock(clock), .reset(reset), .enable(adv_w),
      .in_valid(s5_v_ff), .in_num(s5_n_ff[1]), .in_den(s5_oa_ff),
      .in_side(s5_sat_ff[1]),
      .out_valid(c_v_w[1]), .out_quo(c_q_w[1]), .out_side(sat1_w)
   );
   gab_div #(.NW(24), .DW(16), .QW(8), .SW(1)) u_div_b (
      .clock(clock), .reset(reset), .enable(adv_w),
      .in_valid(s5_v_ff), .in_num(s5_n_ff[2]), .in_den(s5_oa_ff),
      .in_side(s5_sat_ff[2]),
      .out_valid(c_v_w[2]), .out_quo(c_q_w[2]), .out_side(sat2_w)
   );

   // ---------------- final select
   logic [15:0] f_oa_w;
   logic        f_hi_w;
   logic [2:0]  f_sat_w;
   logic [7:0]  f_cov_w;
   pixel_type   f_dst_w;
   logic [23:0] oa255_w;
   logic [7:0]  alpha_w;
   pixel_type   res_w;

   assign {f_oa_w, f_hi_w, f_sat_w[0], f_cov_w, f_dst_w} = side0_out_w;
   assign f_sat_w[1] = sat1_w;
   assign f_sat_w[2] = sat2_w;
   assign oa255_w    = 24'(f_oa_w) * 24'd255;
   assign alpha_w    = oa255_w[QFRAC+8] ? 8'd255 : oa255_w[QFRAC+7:QFRAC];

   always_comb begin
      if (f_cov_w == 8'd0) begin
         res_w = f_dst_w;
      end else if (f_hi_w) begin
         res_w.r = red_ff;
         res_w.g = green_ff;
         res_w.b = blue_ff;
         res_w.a = four_w ? talpha_ff : f_dst_w.a;
      end else if (f_oa_w < LO_THRESH) begin
         res_w = '0;
      end else begin
         res_w.r = f_sat_w[0] ? 8'd255 : c_q_w[0];
         res_w.g = f_sat_w[1] ? 8'd255 : c_q_w[1];
         res_w.b = f_sat_w[2] ? 8'd255 : c_q_w[2];
         res_w.a = four_w ? alpha_w : f_dst_w.a;
      end
   end

   // ---------------- output register
   logic      out_v_ff;
   pixel_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv_w) begin
         out_v_ff <= c_v_w[0] && c_v_w[1] && c_v_w[2];
      end
      if (adv_w) begin
         out_ff <= res_w;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;
endmodule
